// ===== design/assert_macros.svh =====
// Assertion helpers for terminal_line_editor, the one design file that includes them.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/tle_pkg.sv =====
package tle_pkg;

  localparam int LINE_DEPTH_DEF = 64;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_CUR_L  = 8'h44;
  localparam logic [7:0] CH_CUR_R  = 8'h43;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_ERASE  = 3'd1,
    ACT_LEFT   = 3'd2,
    ACT_RIGHT  = 3'd3,
    ACT_TAB    = 3'd4,
    ACT_START  = 3'd5,
    ACT_BYTE   = 3'd6
  } act_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ESC   = 3'd1,
    PH_FIRST = 3'd2,
    PH_VAL   = 3'd3,
    PH_VAL2  = 3'd4
  } esc_phase_t;

  typedef enum logic {
    ST_RUN   = 1'b0,
    ST_FLUSH = 1'b1
  } ctrl_state_t;

  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_INS  = 3'd1,
    CELL_DEL  = 3'd2,
    CELL_SHL  = 3'd3,
    CELL_PUT  = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t   cmd;
    logic [7:0]  data;
  } cell_ctl_t;

endpackage

// ===== design/terminal_line_editor.sv =====
// Terminal line editor: takes one received byte per in_ transaction and returns edit
// results on out_ (action, echoed char, count, last-of-run in tlast). The line is kept
// in a row of byte cells that all shift together, so a printable byte, DEL, TAB or a
// CSI cursor move gives at most one result. CR or any other byte that is not printable
// ASCII, DEL, ESC, TAB or LF (LF is ignored) emits the line: one line-start result, then
// one line-byte result per cycle while out_tready allows, as the row shifts toward cell 0;
// no new byte is taken during that shift-out. The line holds at most LINE_DEPTH - 1
// characters. After reset the line is empty and the escape parser is idle; no clearing
// pass is needed.
module terminal_line_editor #(
  parameter int LINE_DEPTH = tle_pkg::LINE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] action, [10:3] char_value, [16:11] move_count
  output logic        out_tlast   // last_of_run
);

  localparam int PW = $clog2(LINE_DEPTH);

  tle_pkg::ctrl_state_t state_r, state_nxt;
  tle_pkg::esc_phase_t  phase_r, phase_nxt;
  logic [7:0]           csi_r, csi_nxt;
  logic [PW-1:0]        cursor_r, cursor_nxt;
  logic [PW-1:0]        tail_r, tail_nxt;
  logic [PW-1:0]        rem_r, rem_nxt;
  logic                 out_valid_r, out_valid_nxt;
  tle_pkg::act_t        out_action_r, ld_action;
  logic [7:0]           out_char_r, ld_char;
  logic [5:0]           out_move_r, ld_move;
  logic                 out_last_r, ld_last;
  logic                 load;

  logic                 free;
  logic                 in_acc;
  logic [7:0]           b;
  logic [PW:0]          len_w;
  logic [PW-1:0]        len;
  logic [PW-1:0]        flush_len;
  logic                 room;
  logic                 is_digit;
  logic                 cmd_go;
  logic [7:0]           cmd_v;
  logic [11:0]          csi_acc;

  tle_pkg::cell_ctl_t   cell_ctl;
  logic [PW-1:0]        cell_pos;
  logic [7:0]           cell_q [LINE_DEPTH];

  assign free      = !out_valid_r || out_tready;
  assign in_tready = (state_r == tle_pkg::ST_RUN) && free;
  assign in_acc    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign len_w     = (PW+1)'(cursor_r) + (PW+1)'(tail_r);
  assign len       = len_w[PW-1:0];
  assign room      = len_w < (PW+1)'(LINE_DEPTH - 1);
  assign is_digit  = (b >= tle_pkg::CH_ZERO) && (b <= tle_pkg::CH_NINE);
  assign csi_acc   = {1'b0, csi_r, 3'b000} + {3'b000, csi_r, 1'b0}
                   + {4'b0000, b - tle_pkg::CH_ZERO};
  assign cmd_v     = (phase_r == tle_pkg::PH_FIRST) ? 8'd1 : csi_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    csi_nxt       = csi_r;
    cursor_nxt    = cursor_r;
    tail_nxt      = tail_r;
    rem_nxt       = rem_r;
    load          = 1'b0;
    ld_action     = tle_pkg::ACT_INSERT;
    ld_char       = 8'h00;
    ld_move       = 6'd0;
    ld_last       = 1'b1;
    cmd_go        = 1'b0;
    flush_len     = len;
    cell_ctl.cmd  = tle_pkg::CELL_HOLD;
    cell_ctl.data = b;
    cell_pos      = cursor_r;

    unique case (state_r)
      tle_pkg::ST_RUN: begin
        if (in_acc) begin
          unique case (phase_r) inside
            tle_pkg::PH_ESC: begin
              phase_nxt = (b == tle_pkg::CH_LBRACK) ? tle_pkg::PH_FIRST : tle_pkg::PH_IDLE;
            end
            tle_pkg::PH_FIRST: begin
              if (is_digit) begin
                csi_nxt   = b - tle_pkg::CH_ZERO;
                phase_nxt = tle_pkg::PH_VAL;
              end else begin
                csi_nxt = 8'd1;
                cmd_go  = 1'b1;
              end
            end
            tle_pkg::PH_VAL, tle_pkg::PH_VAL2: begin
              if (is_digit) begin
                // second value digits are dropped
                if (phase_r == tle_pkg::PH_VAL) begin
                  csi_nxt = (csi_acc > 12'd255) ? 8'd255 : csi_acc[7:0];
                end
              end else if (b == tle_pkg::CH_SEMI && phase_r == tle_pkg::PH_VAL) begin
                phase_nxt = tle_pkg::PH_VAL2;
              end else begin
                cmd_go = 1'b1;
              end
            end
            tle_pkg::PH_IDLE: begin
              if (b >= tle_pkg::CH_SPACE && b <= tle_pkg::CH_TILDE) begin
                if (room) begin
                  cell_ctl.cmd = tle_pkg::CELL_INS;
                  cursor_nxt   = cursor_r + 1'b1;
                  load         = 1'b1;
                  ld_action    = tle_pkg::ACT_INSERT;
                  ld_char      = b;
                  ld_move      = 6'(tail_r);
                end
              end else if (b == tle_pkg::CH_DEL) begin
                if (cursor_r != '0) begin
                  cell_ctl.cmd = tle_pkg::CELL_DEL;
                  cell_pos     = cursor_r - 1'b1;
                  cursor_nxt   = cursor_r - 1'b1;
                  load         = 1'b1;
                  ld_action    = tle_pkg::ACT_ERASE;
                  ld_move      = 6'(tail_r);
                end
              end else if (b == tle_pkg::CH_ESC) begin
                phase_nxt = tle_pkg::PH_ESC;
              end else if (b == tle_pkg::CH_TAB) begin
                load      = 1'b1;
                ld_action = tle_pkg::ACT_TAB;
                ld_char   = tle_pkg::CH_TAB;
              end else if (b != tle_pkg::CH_LF) begin
                // store the byte (not CR) over the cursor position if there is room, then emit the line
                if (b != tle_pkg::CH_CR && room) begin
                  cell_ctl.cmd = tle_pkg::CELL_PUT;
                  if (tail_r == '0) begin
                    flush_len = PW'(len_w + 1'b1);
                  end
                end
                load       = 1'b1;
                ld_action  = tle_pkg::ACT_START;
                ld_move    = 6'(flush_len);
                ld_last    = (flush_len == '0);
                rem_nxt    = flush_len;
                cursor_nxt = '0;
                tail_nxt   = '0;
                if (flush_len != '0) begin
                  state_nxt = tle_pkg::ST_FLUSH;
                end
              end
            end
            default: phase_nxt = tle_pkg::PH_IDLE;
          endcase

          if (cmd_go) begin
            phase_nxt = tle_pkg::PH_IDLE;
            if (cmd_v != 8'd0) begin
              if (b == tle_pkg::CH_CUR_L && 9'(cmd_v) <= 9'(cursor_r)) begin
                cursor_nxt = cursor_r - PW'(cmd_v);
                tail_nxt   = tail_r + PW'(cmd_v);
                load       = 1'b1;
                ld_action  = tle_pkg::ACT_LEFT;
                ld_move    = 6'(cmd_v);
              end else if (b == tle_pkg::CH_CUR_R && 9'(cmd_v) <= 9'(tail_r)) begin
                cursor_nxt = cursor_r + PW'(cmd_v);
                tail_nxt   = tail_r - PW'(cmd_v);
                load       = 1'b1;
                ld_action  = tle_pkg::ACT_RIGHT;
                ld_move    = 6'(cmd_v);
              end
            end
          end
        end
      end
      tle_pkg::ST_FLUSH: begin
        // advance the row one cell per delivered line byte
        if (free) begin
          load         = 1'b1;
          ld_action    = tle_pkg::ACT_BYTE;
          ld_char      = cell_q[0];
          ld_last      = (rem_r == PW'(1));
          cell_ctl.cmd = tle_pkg::CELL_SHL;
          rem_nxt      = rem_r - 1'b1;
          if (rem_r == PW'(1)) begin
            state_nxt = tle_pkg::ST_RUN;
          end
        end
      end
      default: state_nxt = tle_pkg::ST_RUN;
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tle_pkg::ST_RUN;
      phase_r     <= tle_pkg::PH_IDLE;
      csi_r       <= 8'd0;
      cursor_r    <= '0;
      tail_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      csi_r       <= csi_nxt;
      cursor_r    <= cursor_nxt;
      tail_r      <= tail_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_action_r <= ld_action;
      out_char_r   <= ld_char;
      out_move_r   <= ld_move;
      out_last_r   <= ld_last;
    end
  end

  for (genvar g = 0; g < LINE_DEPTH; g++) begin : g_cell
    logic [7:0] lq;
    logic [7:0] rq;
    if (g == 0) begin : g_head
      assign lq = 8'h00;
    end else begin : g_left
      assign lq = cell_q[g-1];
    end
    if (g == LINE_DEPTH - 1) begin : g_end
      assign rq = 8'h00;
    end else begin : g_right
      assign rq = cell_q[g+1];
    end
    tle_cell #(
      .PW  (PW),
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .ctl     (cell_ctl),
      .pos     (cell_pos),
      .len     (len),
      .left_q  (lq),
      .right_q (rq),
      .q       (cell_q[g])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0000000, out_move_r, out_char_r, out_action_r};
  assign out_tlast  = out_last_r;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_len_bound, len_w <= (PW+1)'(LINE_DEPTH - 1), "line length past capacity")
  `ASSERT_IMPLY(a_flush_no_in, state_r == tle_pkg::ST_FLUSH, !in_tready, "byte taken in flush")
  `ASSERT_IMPLY(a_flush_clear, state_r == tle_pkg::ST_FLUSH, len_w == '0, "line kept in flush")
  `ASSERT_IMPLY(a_flush_rem, state_r == tle_pkg::ST_FLUSH, rem_r != '0, "flush with no bytes left")

endmodule

// ===== design/tle_cell.sv =====
module tle_cell #(
  parameter int PW  = 6,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  tle_pkg::cell_ctl_t  ctl,
  input  logic [PW-1:0]       pos,
  input  logic [PW-1:0]       len,
  input  logic [7:0]          left_q,
  input  logic [7:0]          right_q,
  output logic [7:0]          q
);

  localparam logic [PW:0] ME = (PW+1)'(IDX);

  logic [7:0] q_r;
  logic [7:0] q_nxt;
  logic [PW:0] pos_w;
  logic [PW:0] len_w;

  assign pos_w = {1'b0, pos};
  assign len_w = {1'b0, len};
  assign q     = q_r;

  always_comb begin
    q_nxt = q_r;
    unique case (ctl.cmd)
      tle_pkg::CELL_INS: begin
        // open a gap at the cursor: cells right of it take their left neighbor
        if (ME == pos_w) begin
          q_nxt = ctl.data;
        end else if (ME > pos_w && ME <= len_w) begin
          q_nxt = left_q;
        end
      end
      tle_pkg::CELL_DEL: begin
        // close the gap: pos is the new cursor
        if (ME >= pos_w && (ME + 1'b1) < len_w) begin
          q_nxt = right_q;
        end
      end
      tle_pkg::CELL_SHL: q_nxt = right_q;
      tle_pkg::CELL_PUT: begin
        if (ME == pos_w) begin
          q_nxt = ctl.data;
        end
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

// ===== verif/tb.sv =====
module tb;

  localparam int DEPTH        = tle_pkg::LINE_DEPTH_DEF;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 210;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    tle_pkg::act_t act;
    logic [7:0]    ch;
    logic [5:0]    cnt;
    logic          last;
  } edit_result_t;

  class line_editor_scoreboard;
    logic [7:0]          line_buf [DEPTH];
    int                  cursor;
    int                  tail;
    tle_pkg::esc_phase_t phase;
    int                  csi_val;
    edit_result_t        expected_q[$];
    int                  mismatches;

    function new();
      foreach (line_buf[i]) line_buf[i] = 8'h00;
      cursor     = 0;
      tail       = 0;
      phase      = tle_pkg::PH_IDLE;
      csi_val    = 0;
      mismatches = 0;
    endfunction

    function void push(tle_pkg::act_t act, logic [7:0] ch, int cnt);
      edit_result_t r;
      r.act  = act;
      r.ch   = ch;
      r.cnt  = 6'(cnt);
      r.last = 1'b0;
      expected_q.push_back(r);
    endfunction

    // Final byte of a CSI: apply the cursor move if it fits on that side.
    function void end_csi(logic [7:0] b);
      phase = tle_pkg::PH_IDLE;
      if (csi_val == 0) return;
      if (b == tle_pkg::CH_CUR_L && csi_val <= cursor) begin
        cursor -= csi_val;
        tail   += csi_val;
        push(tle_pkg::ACT_LEFT, 8'h00, csi_val);
      end else if (b == tle_pkg::CH_CUR_R && csi_val <= tail) begin
        cursor += csi_val;
        tail   -= csi_val;
        push(tle_pkg::ACT_RIGHT, 8'h00, csi_val);
      end
    endfunction

    function void note_rx(logic [7:0] b);
      int  len;
      int  first;
      int  i;
      bit  digit;
      len   = cursor + tail;
      first = expected_q.size();
      digit = (b >= tle_pkg::CH_ZERO && b <= tle_pkg::CH_NINE);
      case (phase)
        tle_pkg::PH_ESC: phase = (b == tle_pkg::CH_LBRACK) ? tle_pkg::PH_FIRST : tle_pkg::PH_IDLE;
        tle_pkg::PH_FIRST: begin
          if (digit) begin
            csi_val = int'(b - tle_pkg::CH_ZERO);
            phase   = tle_pkg::PH_VAL;
          end else begin
            csi_val = 1;
            end_csi(b);
          end
        end
        tle_pkg::PH_VAL, tle_pkg::PH_VAL2: begin
          if (digit) begin
            if (phase == tle_pkg::PH_VAL) begin
              csi_val = csi_val * 10 + int'(b - tle_pkg::CH_ZERO);
              if (csi_val > 255) csi_val = 255;
            end
          end else if (b == tle_pkg::CH_SEMI && phase == tle_pkg::PH_VAL) begin
            phase = tle_pkg::PH_VAL2;
          end else begin
            end_csi(b);
          end
        end
        default: begin
          if (b >= tle_pkg::CH_SPACE && b <= tle_pkg::CH_TILDE) begin
            if (len < DEPTH - 1) begin
              for (i = len; i > cursor; i--) line_buf[i] = line_buf[i - 1];
              line_buf[cursor] = b;
              cursor++;
              push(tle_pkg::ACT_INSERT, b, tail);
            end
          end else if (b == tle_pkg::CH_DEL) begin
            if (cursor > 0) begin
              cursor--;
              for (i = cursor; i + 1 < len; i++) line_buf[i] = line_buf[i + 1];
              push(tle_pkg::ACT_ERASE, 8'h00, tail);
            end
          end else if (b == tle_pkg::CH_ESC) begin
            phase = tle_pkg::PH_ESC;
          end else if (b == tle_pkg::CH_TAB) begin
            push(tle_pkg::ACT_TAB, tle_pkg::CH_TAB, 0);
          end else if (b != tle_pkg::CH_LF) begin
            // other bytes but CR land in the line unless it is full
            if (b != tle_pkg::CH_CR && len < DEPTH - 1) begin
              line_buf[cursor] = b;
              cursor++;
              if (tail > 0) tail--;
            end
            len = cursor + tail;
            push(tle_pkg::ACT_START, 8'h00, len);
            for (i = 0; i < len; i++) push(tle_pkg::ACT_BYTE, line_buf[i], 0);
            cursor = 0;
            tail   = 0;
          end
        end
      endcase
      if (expected_q.size() > first) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void check_result(edit_result_t got);
      edit_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: act %0d char %02h count %0d last %0b",
                   got.act, got.ch, got.cnt, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got.act !== want.act || got.ch !== want.ch || got.cnt !== want.cnt ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected act %0d char %02h count %0d last %0b,",
                    " got act %0d char %02h count %0d last %0b"},
                   want.act, want.ch, want.cnt, want.last,
                   got.act, got.ch, got.cnt, got.last);
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;

  bit                    idle_on = 1'b1;
  int                    sent;
  int                    quiet_cycles;
  line_editor_scoreboard sb;

  terminal_line_editor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= !(idle_on && $urandom_range(0, 99) < 8);
  end

  // Note inputs before checking outputs so a same-edge result still finds its expectation.
  always @(posedge clk) begin
    edit_result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_rx(in_tdata);
      if (out_tvalid && out_tready) begin
        got.act  = tle_pkg::act_t'(out_tdata[2:0]);
        got.ch   = out_tdata[10:3];
        got.cnt  = out_tdata[16:11];
        got.last = out_tlast;
        sb.check_result(got);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Hold the byte until the transaction completes; drop valid only for an idle gap.
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_decimal(input int value);
    int digs[$];
    int v;
    v = value;
    do begin
      digs.push_front(v % 10);
      v = v / 10;
    end while (v > 0);
    foreach (digs[i]) send_byte(tle_pkg::CH_ZERO + 8'(digs[i]));
  endtask

  // ESC [ count ; second cmd, with count or second left out when negative
  task automatic csi_seq(input logic [7:0] cmd, input int count, input int second);
    send_byte(tle_pkg::CH_ESC);
    send_byte(tle_pkg::CH_LBRACK);
    if (count >= 0) send_decimal(count);
    if (second >= 0) begin
      send_byte(tle_pkg::CH_SEMI);
      send_decimal(second);
    end
    send_byte(cmd);
  endtask

  task automatic type_text(input int n);
    repeat (n) send_byte(8'($urandom_range(32, 126)));
  endtask

  initial begin
    int         kind;
    int         cnt;
    int         second;
    logic [7:0] c;
    logic [7:0] cmd;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(tle_pkg::CH_CR);       // empty line
    send_byte(tle_pkg::CH_DEL);      // erase at line start
    send_byte(tle_pkg::CH_SPACE);
    send_byte(tle_pkg::CH_TILDE);
    send_byte(tle_pkg::CH_TAB);
    send_byte(tle_pkg::CH_LF);
    csi_seq(tle_pkg::CH_CUR_L, -1, -1);    // default step
    send_byte(8'h41);                      // insert with a tail to redraw
    csi_seq(tle_pkg::CH_CUR_R, 0, -1);     // zero step
    csi_seq(tle_pkg::CH_CUR_L, 300, 4);    // saturated count, second value, too far
    send_byte(tle_pkg::CH_ESC);
    send_byte(8'h78);                      // ESC without a CSI
    send_byte(tle_pkg::CH_ESC);
    send_byte(tle_pkg::CH_LBRACK);
    send_byte(tle_pkg::CH_ESC);            // ESC as the command: unknown
    send_byte(8'h01);                      // stored over the tail, then flushed
    send_byte(8'hFF);

    // Fill the line past its limit, sweep the cursor end to end, then flush.
    type_text(DEPTH + 1);
    csi_seq(tle_pkg::CH_CUR_L, DEPTH - 1, -1);
    csi_seq(tle_pkg::CH_CUR_R, DEPTH - 1, -1);
    csi_seq(tle_pkg::CH_CUR_L, DEPTH + 6, -1);
    send_byte(tle_pkg::CH_DEL);
    type_text(2);
    send_byte(8'h01);

    while (sent < RANDOM_ITEMS) begin
      idle_on = !(sent >= 110 && sent < 160);
      kind    = $urandom_range(0, 99);
      if (kind < 35) begin
        type_text($urandom_range(1, 6));
      end else if (kind < 45) begin
        send_byte(tle_pkg::CH_DEL);
      end else if (kind < 65) begin
        cnt = $urandom_range(0, 9);
        if (cnt < 2) cnt = -1;
        else if (cnt < 8) cnt = $urandom_range(0, 12);
        else cnt = $urandom_range(13, 999);
        if ($urandom_range(0, 9) == 0) cmd = 8'($urandom_range(64, 126));
        else cmd = $urandom_range(0, 1) ? tle_pkg::CH_CUR_L : tle_pkg::CH_CUR_R;
        second = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 99) : -1;
        csi_seq(cmd, cnt, second);
      end else if (kind < 70) begin
        send_byte($urandom_range(0, 1) ? tle_pkg::CH_TAB : tle_pkg::CH_LF);
      end else if (kind < 80) begin
        send_byte(tle_pkg::CH_CR);
      end else if (kind < 85) begin
        do c = 8'($urandom_range(0, 31));
        while (c == tle_pkg::CH_TAB || c == tle_pkg::CH_LF || c == tle_pkg::CH_CR ||
               c == tle_pkg::CH_ESC);
        if ($urandom_range(0, 1)) c = 8'($urandom_range(128, 255));
        send_byte(c);
      end else if (kind < 93) begin
        send_byte(8'($urandom));
      end else begin
        // broken escape: stray byte after ESC, or a CSI ended by any byte
        send_byte(tle_pkg::CH_ESC);
        if ($urandom_range(0, 1)) begin
          send_byte(8'($urandom));
        end else begin
          send_byte(tle_pkg::CH_LBRACK);
          repeat ($urandom_range(0, 3)) send_byte(tle_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
          send_byte(8'($urandom));
        end
      end
    end

    in_tvalid <= 1'b0;
    idle_on = 1'b1;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
